// ----- hdl/avr_pkg.sv -----
// ----------------------------------------------------------------------------
// avr_pkg
// Shared widths, angle constants and quadrant codes for the axis-angle rotator.
// ----------------------------------------------------------------------------
package avr_pkg;

    localparam int AXIS_W   = 18;
    localparam int ANGLE_W  = 17;
    localparam int REM_W    = 15;   // angle remainder within one quadrant
    localparam int TRIG_W   = 18;   // signed Q16 sine / cosine
    localparam int OMC_W    = 19;   // signed Q16 one minus cosine
    localparam int X_W      = 31;   // angle in radians, Q30
    localparam int X2_W     = 32;   // angle squared, Q30
    localparam int T_W      = 31;   // Horner accumulator, Q30

    localparam logic [ANGLE_W-1:0] FULL_TURN     = 17'd92160;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER = 17'd69120;
    localparam logic [ANGLE_W-1:0] HALF_TURN     = 17'd46080;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN  = 17'd23040;

    // round(pi / 46080 * 2^32)
    localparam logic [18:0] RAD_PER_STEP = 19'd292818;

    localparam logic [T_W-1:0] Q30_ONE = 31'h4000_0000;

    localparam int CELL_LAT  = 3;
    localparam int COS_CELLS = 7;
    localparam int SIN_CELLS = 6;
    localparam int TRIG_LAT  = 25;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

endpackage

// ----- hdl/avr_horner_cell.sv -----
// ----------------------------------------------------------------------------
// avr_horner_cell
// One Horner step of the Taylor series: t_out = 1 - x2 * t_in / (K * (K + 1)),
// Q30, truncating division by a constant via reciprocal and one correction.
// ----------------------------------------------------------------------------
module avr_horner_cell #(
    parameter int K = 1
) (
    input  logic                        clk,
    input  logic [avr_pkg::X2_W-1:0]    x2_in,
    input  logic [avr_pkg::T_W-1:0]     t_in,
    output logic [avr_pkg::X2_W-1:0]    x2_out,
    output logic [avr_pkg::T_W-1:0]     t_out
);
    import avr_pkg::*;

    localparam int DIV       = K * (K + 1);
    localparam int N_W       = 33;
    localparam int SHIFT     = N_W + $clog2(DIV);
    localparam logic [63:0] RECIP = (64'd1 << SHIFT) / 64'(DIV);
    localparam int RECIP_W   = N_W + 1;
    localparam int RP_W      = N_W + RECIP_W;
    localparam int QM_W      = N_W + 8;

    logic [X2_W-1:0] x2_d1_reg, x2_d2_reg;
    logic [N_W-1:0]  n_reg, n_d2_reg, q0_reg;
    logic [N_W-1:0]  n_next, q0_next;
    logic [T_W-1:0]  t_next;
    logic [62:0]     prod;
    logic [RP_W-1:0] rprod;
    logic [QM_W-1:0] qm, rem;
    logic [N_W:0]    q_fix;

    always_comb
    begin
        prod    = 63'(x2_in) * 63'(t_in);
        n_next  = prod[62:30];
        rprod   = RP_W'(n_reg) * RP_W'(RECIP[RECIP_W-1:0]);
        q0_next = N_W'(rprod >> SHIFT);
        // q0 is the true quotient or one short of it
        qm      = QM_W'(q0_reg) * QM_W'(DIV);
        rem     = QM_W'(n_d2_reg) - qm;
        q_fix   = (N_W+1)'(q0_reg) + (N_W+1)'(rem >= QM_W'(DIV));
        t_next  = T_W'((N_W+1)'(Q30_ONE) - q_fix);
    end

    always_ff @(posedge clk)
    begin
        x2_d1_reg <= x2_in;
        n_reg     <= n_next;
        x2_d2_reg <= x2_d1_reg;
        n_d2_reg  <= n_reg;
        q0_reg    <= q0_next;
        x2_out    <= x2_d2_reg;
        t_out     <= t_next;
    end

endmodule

// ----- hdl/avr_trig.sv -----
// ----------------------------------------------------------------------------
// avr_trig
// Sine, cosine and one minus cosine in Q16 from an angle in 1/256 degree,
// through two chains of Horner cells.
// ----------------------------------------------------------------------------
module avr_trig (
    input  logic                                clk,
    input  logic [avr_pkg::ANGLE_W-1:0]         ang,
    output logic signed [avr_pkg::TRIG_W-1:0]   sin_q,
    output logic signed [avr_pkg::TRIG_W-1:0]   cos_q,
    output logic signed [avr_pkg::OMC_W-1:0]    omc_q
);
    import avr_pkg::*;

    localparam int Q_DLY = TRIG_LAT - 2;
    localparam int X_DLY = CELL_LAT * SIN_CELLS + 1;

    quad_t           quad_reg, quad_next;
    quad_t           quad_line [Q_DLY];
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [X_W-1:0]  x_reg;
    logic [X_W-1:0]  x_line [X_DLY];
    logic [X2_W-1:0] x2_reg;
    logic [33:0]     xp;
    logic [61:0]     xx, sp;
    logic [31:0]     sx_reg, sx_d1_reg, sx_d2_reg;

    logic [X2_W-1:0] cos_x2 [COS_CELLS+1];
    logic [T_W-1:0]  cos_t  [COS_CELLS+1];
    logic [X2_W-1:0] sin_x2 [SIN_CELLS+1];
    logic [T_W-1:0]  sin_t  [SIN_CELLS+1];

    logic [16:0]              sr, cq;
    logic signed [TRIG_W-1:0] s_next, c_next;

    function automatic logic [16:0] to_q16(input logic [31:0] v);
        logic [31:0] cv;
        cv = (v > 32'h4000_0000) ? 32'h4000_0000 : v;
        cv = cv + 32'd8192;
        return cv[30:14];
    endfunction

    always_comb
    begin
        if (ang >= THREE_QUARTER)
        begin
            quad_next = QUAD_3;
            rem_next  = REM_W'(ang - THREE_QUARTER);
        end
        else if (ang >= HALF_TURN)
        begin
            quad_next = QUAD_2;
            rem_next  = REM_W'(ang - HALF_TURN);
        end
        else if (ang >= QUARTER_TURN)
        begin
            quad_next = QUAD_1;
            rem_next  = REM_W'(ang - QUARTER_TURN);
        end
        else
        begin
            quad_next = QUAD_0;
            rem_next  = REM_W'(ang);
        end
    end

    assign xp = 34'(rem_reg) * 34'(RAD_PER_STEP);
    assign xx = 62'(x_reg) * 62'(x_reg);
    assign sp = 62'(x_line[X_DLY-1]) * 62'(sin_t[SIN_CELLS]);

    always_ff @(posedge clk)
    begin
        quad_reg     <= quad_next;
        rem_reg      <= rem_next;
        x_reg        <= xp[32:2];
        x2_reg       <= xx[61:30];
        quad_line[0] <= quad_reg;
        for (int i = 1; i < Q_DLY; i++)
            quad_line[i] <= quad_line[i-1];
        x_line[0] <= x_reg;
        for (int i = 1; i < X_DLY; i++)
            x_line[i] <= x_line[i-1];
        sx_reg    <= sp[61:30];
        sx_d1_reg <= sx_reg;
        sx_d2_reg <= sx_d1_reg;
    end

    assign cos_x2[0] = x2_reg;
    assign cos_t[0]  = Q30_ONE;
    assign sin_x2[0] = x2_reg;
    assign sin_t[0]  = Q30_ONE;

    for (genvar g = 0; g < COS_CELLS; g++)
    begin : g_cos
        avr_horner_cell #(.K(2 * COS_CELLS - 1 - 2 * g)) u_cell (
            .clk    (clk),
            .x2_in  (cos_x2[g]),
            .t_in   (cos_t[g]),
            .x2_out (cos_x2[g+1]),
            .t_out  (cos_t[g+1])
        );
    end

    for (genvar g = 0; g < SIN_CELLS; g++)
    begin : g_sin
        avr_horner_cell #(.K(2 * SIN_CELLS - 2 * g)) u_cell (
            .clk    (clk),
            .x2_in  (sin_x2[g]),
            .t_in   (sin_t[g]),
            .x2_out (sin_x2[g+1]),
            .t_out  (sin_t[g+1])
        );
    end

    always_comb
    begin
        sr = to_q16(sx_d2_reg);
        cq = to_q16(32'(cos_t[COS_CELLS]));
        case (quad_line[Q_DLY-1])
            QUAD_0:
            begin
                s_next = $signed({1'b0, sr});
                c_next = $signed({1'b0, cq});
            end
            QUAD_1:
            begin
                s_next = $signed({1'b0, cq});
                c_next = -$signed({1'b0, sr});
            end
            QUAD_2:
            begin
                s_next = -$signed({1'b0, sr});
                c_next = -$signed({1'b0, cq});
            end
            default:
            begin
                s_next = -$signed({1'b0, cq});
                c_next = $signed({1'b0, sr});
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sin_q <= s_next;
        cos_q <= c_next;
        omc_q <= OMC_W'(65536) - OMC_W'(c_next);
    end

endmodule

// ----- hdl/axis_angle_vector_rotation.sv -----
// Done is the accepted start carried down a valid shift register beside the datapath.
// Throughput: one item per cycle; busy is always low.
// Latency is set by the cosine chain of seven three-stage Horner cells.
// Reset clears only the item valid pipeline; no item is in flight after reset.
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation
// Rotates a vector about a unit axis by Rodrigues' formula, fully pipelined.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation #(
    parameter int COMPONENT_WIDTH = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COMPONENT_WIDTH-1:0]   vec_x,
    input  logic signed [COMPONENT_WIDTH-1:0]   vec_y,
    input  logic signed [COMPONENT_WIDTH-1:0]   vec_z,
    input  logic signed [avr_pkg::AXIS_W-1:0]   axis_x,
    input  logic signed [avr_pkg::AXIS_W-1:0]   axis_y,
    input  logic signed [avr_pkg::AXIS_W-1:0]   axis_z,
    input  logic [avr_pkg::ANGLE_W-1:0]         angle,
    output logic                                done,
    output logic signed [COMPONENT_WIDTH-1:0]   out_x,
    output logic signed [COMPONENT_WIDTH-1:0]   out_y,
    output logic signed [COMPONENT_WIDTH-1:0]   out_z,
    output logic                                saturated
);
    import avr_pkg::*;

    localparam int CW      = COMPONENT_WIDTH;
    localparam int PROD_W  = CW + AXIS_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int DOTF_W  = DOT_W + 1 - 16;
    localparam int CR_W    = PROD_W + 2 - 16;
    localparam int PA_W    = AXIS_W + DOTF_W;
    localparam int PROJ_W  = PA_W + 1 - 16;
    localparam int T1_W    = CW + TRIG_W;
    localparam int T2_W    = CR_W + TRIG_W;
    localparam int T3_W    = PROJ_W + OMC_W;
    localparam int SUM_W   = T3_W + 2;
    localparam int RS_W    = SUM_W + 1 - 16;
    localparam int VEC_DLY = TRIG_LAT - 4;
    localparam int PIPE    = TRIG_LAT + 3;

    logic                       vld_reg;
    logic [PIPE-1:0]            vld_line_reg;
    logic [ANGLE_W-1:0]         ang_wrap, ang_reg;
    logic signed [CW-1:0]       v_reg [3];
    logic signed [AXIS_W-1:0]   a_reg [3];
    logic signed [CW-1:0]       vd_reg [VEC_DLY][3];
    logic signed [AXIS_W-1:0]   ad_reg [VEC_DLY][3];

    logic signed [PROD_W-1:0]   prod_reg [3][3];
    logic signed [CW-1:0]       v1_reg [3], v2_reg [3], v3_reg [3], v4_reg [3];
    logic signed [AXIS_W-1:0]   a1_reg [3], a2_reg [3];
    logic signed [DOT_W:0]      dot_rnd;
    logic signed [PROD_W+1:0]   cr_rnd [3];
    logic signed [DOTF_W-1:0]   dotf_reg;
    logic signed [CR_W-1:0]     cr_reg [3], cr3_reg [3], cr4_reg [3];
    logic signed [PA_W-1:0]     pa_reg [3];
    logic signed [PA_W:0]       pa_rnd [3];
    logic signed [PROJ_W-1:0]   proj_reg [3];

    logic signed [TRIG_W-1:0]   sin_q, cos_q;
    logic signed [OMC_W-1:0]    omc_q;
    logic signed [T1_W-1:0]     t1_reg [3];
    logic signed [T2_W-1:0]     t2_reg [3];
    logic signed [T3_W-1:0]     t3_reg [3];
    logic signed [SUM_W:0]      sum_rnd [3];
    logic signed [RS_W-1:0]     rs_reg [3];
    logic signed [CW-1:0]       res [3];
    logic [2:0]                 clip;

    assign busy     = 1'b0;
    assign ang_wrap = (angle >= FULL_TURN) ? ANGLE_W'(angle - FULL_TURN) : angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= 1'b0;
            vld_line_reg <= '0;
        end
        else
        begin
            vld_reg      <= start && !busy;
            vld_line_reg <= {vld_line_reg[PIPE-2:0], vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_wrap;
        v_reg   <= '{vec_x, vec_y, vec_z};
        a_reg   <= '{axis_x, axis_y, axis_z};
        vd_reg[0] <= v_reg;
        ad_reg[0] <= a_reg;
        for (int k = 1; k < VEC_DLY; k++)
        begin
            vd_reg[k] <= vd_reg[k-1];
            ad_reg[k] <= ad_reg[k-1];
        end
    end

    avr_trig u_trig (
        .clk   (clk),
        .ang   (ang_reg),
        .sin_q (sin_q),
        .cos_q (cos_q),
        .omc_q (omc_q)
    );

    // rounding scale-down by 2^16 is floor((x + 2^15) / 2^16)
    always_comb
    begin
        dot_rnd = (DOT_W+1)'(prod_reg[0][0]) + (DOT_W+1)'(prod_reg[1][1])
                + (DOT_W+1)'(prod_reg[2][2]) + (DOT_W+1)'(32768);
        cr_rnd[0] = (PROD_W+2)'(prod_reg[1][2]) - (PROD_W+2)'(prod_reg[2][1])
                  + (PROD_W+2)'(32768);
        cr_rnd[1] = (PROD_W+2)'(prod_reg[2][0]) - (PROD_W+2)'(prod_reg[0][2])
                  + (PROD_W+2)'(32768);
        cr_rnd[2] = (PROD_W+2)'(prod_reg[0][1]) - (PROD_W+2)'(prod_reg[1][0])
                  + (PROD_W+2)'(32768);
        for (int i = 0; i < 3; i++)
        begin
            pa_rnd[i]  = (PA_W+1)'(pa_reg[i]) + (PA_W+1)'(32768);
            sum_rnd[i] = (SUM_W+1)'(t1_reg[i]) + (SUM_W+1)'(t2_reg[i])
                       + (SUM_W+1)'(t3_reg[i]) + (SUM_W+1)'(32768);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                prod_reg[i][j] <= ad_reg[VEC_DLY-1][i] * vd_reg[VEC_DLY-1][j];
            v1_reg[i]   <= vd_reg[VEC_DLY-1][i];
            a1_reg[i]   <= ad_reg[VEC_DLY-1][i];
            v2_reg[i]   <= v1_reg[i];
            a2_reg[i]   <= a1_reg[i];
            cr_reg[i]   <= cr_rnd[i][PROD_W+1:16];
            v3_reg[i]   <= v2_reg[i];
            cr3_reg[i]  <= cr_reg[i];
            pa_reg[i]   <= a2_reg[i] * dotf_reg;
            v4_reg[i]   <= v3_reg[i];
            cr4_reg[i]  <= cr3_reg[i];
            proj_reg[i] <= pa_rnd[i][PA_W:16];
            t1_reg[i]   <= v4_reg[i] * cos_q;
            t2_reg[i]   <= cr4_reg[i] * sin_q;
            t3_reg[i]   <= proj_reg[i] * omc_q;
            rs_reg[i]   <= sum_rnd[i][SUM_W:16];
        end
        dotf_reg <= dot_rnd[DOT_W:16];
    end

    // clip when the bits above the output sign are not all copies of it
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            clip[i] = (rs_reg[i][RS_W-1:CW-1] != '0) && (rs_reg[i][RS_W-1:CW-1] != '1);
            if (clip[i])
                res[i] = rs_reg[i][RS_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            else
                res[i] = rs_reg[i][CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        out_x     <= res[0];
        out_y     <= res[1];
        out_z     <= res[2];
        saturated <= |clip;
    end

    assign done = vld_line_reg[PIPE-1];

endmodule
